>>> src/fps_pkg.sv
// shared types, constants and the range bounds function of the playback sequencer
// no dependencies; imported by fps_divider, fps_advance and frame_playback_sequencer_core
package fps_pkg;

   localparam int FRAME_BITS   = 16;
   localparam int WORK_BITS    = FRAME_BITS + 2;
   localparam int SPAN_BITS    = FRAME_BITS + 1;
   localparam int CNT_BITS     = FRAME_BITS + 2;
   localparam int ACC_BITS     = 32;
   localparam int ELAPSED_BITS = 24;
   localparam int PERIOD_BITS  = 27;
   localparam int KIND_BITS    = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = PERIOD_BITS;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_TICK     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_BACK     = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_FORWARD  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_TOGGLE   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_SET      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEQ_LEN    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOPING    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOUNCY     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REVERSE    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD     = 3'd6;

   // register reset values
   localparam logic [FRAME_BITS-1:0]  RESET_RANGE_LOW  = 16'd1;
   localparam logic [FRAME_BITS-1:0]  RESET_RANGE_HIGH = 16'd65535;
   localparam logic [FRAME_BITS-1:0]  RESET_SEQ_LEN    = 16'd65535;
   localparam logic                   RESET_LOOPING    = 1'b1;
   localparam logic                   RESET_BOUNCY     = 1'b0;
   localparam logic                   RESET_REVERSE    = 1'b0;
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD     = 27'd33333;
   localparam logic [FRAME_BITS-1:0]  RESET_FRAME      = 16'd1;

   typedef logic [FRAME_BITS-1:0]       frame_type;
   typedef logic signed [WORK_BITS-1:0] work_type;

   typedef struct packed {
      frame_type lo;
      frame_type hi;
   } range_type;

   typedef struct packed {
      logic looping;
      logic bouncy;
      logic reverse;
   } mode_type;

   typedef struct packed {
      logic                   start;
      logic [ACC_BITS-1:0]    dividend;
      logic [PERIOD_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [ACC_BITS-1:0]    quot;
      logic [PERIOD_BITS-1:0] rem;
   } div_rsp_type;

   // wrap or clamp a frame into the effective range
   function automatic frame_type in_bounds(work_type v, range_type rng, logic looping);
      work_type lo_w;
      work_type hi_w;
      work_type f;
      lo_w = $signed({2'b00, rng.lo});
      hi_w = $signed({2'b00, rng.hi});
      f    = v;
      if (f > hi_w) f = looping ? lo_w : hi_w;
      if (f < lo_w) f = looping ? hi_w : lo_w;
      return f[FRAME_BITS-1:0];
   endfunction

endpackage

>>> src/frame_playback_sequencer_core.sv
// playback frame sequencer top level: registers, sequencer, accumulator, result register
// depends on fps_pkg, fps_divider and fps_advance
//
// step, toggle, set frame, unused kinds and ticks without an advance pass through the setup,
//   execute and finish states into the output register
// ticks that advance also wait for the period division, for a second division when the advance
//   count is longer than span + 2 (it is then folded onto the playback cycle), and then take one
//   advance step per remaining step (at most about 3 x span steps); the shared divider and
//   the single advance unit serve one item at a time
// throughput: one item at a time, next request taken once the result is in the output register
// reset: synchronous, active high; frame 1, forward, stopped, accumulator 0, registers to defaults
module frame_playback_sequencer_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fps_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [fps_pkg::ELAPSED_BITS-1:0]   req_elapsed_us,
   input  logic [fps_pkg::FRAME_BITS-1:0]     req_new_frame,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fps_pkg::FRAME_BITS-1:0]     rsp_frame_now,
   output logic                               rsp_going_back,
   output logic                               rsp_is_playing,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fps_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [fps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import fps_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETUP  = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_DIV1   = 3'd3;
   localparam logic [2:0] S_DIV2   = 3'd4;
   localparam logic [2:0] S_STEP   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   // configuration registers
   frame_type              cfg_range_low_ff;
   frame_type              cfg_range_high_ff;
   frame_type              cfg_seq_len_ff;
   logic                   cfg_looping_ff;
   logic                   cfg_bouncy_ff;
   logic                   cfg_reverse_ff;
   logic [PERIOD_BITS-1:0] cfg_period_ff;

   // sequencer and working registers
   logic [2:0]              state_ff,     state_in;
   logic [KIND_BITS-1:0]    kind_ff,      kind_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff,   elapsed_in;
   frame_type               new_frame_ff, new_frame_in;
   frame_type               lo_ff,        lo_in;
   frame_type               hi_ff,        hi_in;
   logic [CNT_BITS-1:0]     cyc_len_ff,   cyc_len_in;
   logic [SPAN_BITS-1:0]    t0_ff,        t0_in;
   logic [ACC_BITS-1:0]     acc_ff,       acc_in;
   work_type                f_work_ff,    f_work_in;
   logic [CNT_BITS-1:0]     step_cnt_ff,  step_cnt_in;

   // architectural state
   frame_type               frame_ff,     frame_in;
   logic                    dir_ff,       dir_in;
   logic                    playing_ff,   playing_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   frame_type               rsp_frame_ff, rsp_frame_in;
   logic                    rsp_dir_ff,   rsp_dir_in;
   logic                    rsp_play_ff,  rsp_play_in;

   // combinational helpers
   frame_type               lo_c;
   frame_type               hi_min_c;
   frame_type               hi_c;
   logic [SPAN_BITS-1:0]    span_c;
   logic [ACC_BITS:0]       acc_sum_c;
   logic [ACC_BITS-1:0]     acc_sat_c;
   frame_type               bound_c;
   range_type               rng;
   mode_type                mode;
   frame_type               adv_frame;
   logic                    adv_dir;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign rng.lo       = lo_ff;
   assign rng.hi       = hi_ff;
   assign mode.looping = cfg_looping_ff;
   assign mode.bouncy  = cfg_bouncy_ff;
   assign mode.reverse = cfg_reverse_ff;

   // shared period divider: elapsed periods first, then folding onto the playback cycle
   fps_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // single advance unit, reused once per frame step
   fps_advance u_advance (
      .frame_cur  (f_work_ff[FRAME_BITS-1:0]),
      .dir_cur    (dir_ff),
      .rng        (rng),
      .mode       (mode),
      .frame_next (adv_frame),
      .dir_next   (adv_dir)
   );

   // register writes are taken at any time; software must only write while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_range_low_ff  <= RESET_RANGE_LOW;
         cfg_range_high_ff <= RESET_RANGE_HIGH;
         cfg_seq_len_ff    <= RESET_SEQ_LEN;
         cfg_looping_ff    <= RESET_LOOPING;
         cfg_bouncy_ff     <= RESET_BOUNCY;
         cfg_reverse_ff    <= RESET_REVERSE;
         cfg_period_ff     <= RESET_PERIOD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANGE_LOW:  cfg_range_low_ff  <= csr_wdata[FRAME_BITS-1:0];
            CSR_RANGE_HIGH: cfg_range_high_ff <= csr_wdata[FRAME_BITS-1:0];
            CSR_SEQ_LEN:    cfg_seq_len_ff    <= csr_wdata[FRAME_BITS-1:0];
            CSR_LOOPING:    cfg_looping_ff    <= csr_wdata[0];
            CSR_BOUNCY:     cfg_bouncy_ff     <= csr_wdata[0];
            CSR_REVERSE:    cfg_reverse_ff    <= csr_wdata[0];
            CSR_PERIOD:     cfg_period_ff     <= csr_wdata[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // effective range: low end at least 1, high end limited by sequence length
      lo_c     = (cfg_range_low_ff == '0) ? FRAME_BITS'(1) : cfg_range_low_ff;
      hi_min_c = (cfg_range_high_ff < cfg_seq_len_ff) ? cfg_range_high_ff : cfg_seq_len_ff;
      hi_c     = (hi_min_c < lo_c) ? lo_c : hi_min_c;

      span_c    = {1'b0, hi_ff} - {1'b0, lo_ff} + SPAN_BITS'(1);
      // accumulator add saturates at all ones
      acc_sum_c = {1'b0, acc_ff} + (ACC_BITS + 1)'(elapsed_ff);
      acc_sat_c = acc_sum_c[ACC_BITS] ? '1 : acc_sum_c[ACC_BITS-1:0];
      bound_c   = in_bounds(f_work_ff, rng, cfg_looping_ff);
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      elapsed_in   = elapsed_ff;
      new_frame_in = new_frame_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cyc_len_in   = cyc_len_ff;
      t0_in        = t0_ff;
      acc_in       = acc_ff;
      f_work_in    = f_work_ff;
      step_cnt_in  = step_cnt_ff;
      frame_in     = frame_ff;
      dir_in       = dir_ff;
      playing_in   = playing_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      div_req.start    = 1'b0;
      div_req.dividend = acc_sat_c - ACC_BITS'(1);
      div_req.divisor  = cfg_period_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind;
               elapsed_in   = req_elapsed_us;
               new_frame_in = req_new_frame;
               state_in     = S_SETUP;
            end
         end

         S_SETUP: begin
            lo_in    = lo_c;
            hi_in    = hi_c;
            state_in = S_EXEC;
         end

         S_EXEC: begin
            // playback cycle length: span when wrapping, a fixed point when clamping,
            // there and back when bouncing
            if (cfg_bouncy_ff) begin
               if (span_c == SPAN_BITS'(1)) cyc_len_in = CNT_BITS'(2);
               else cyc_len_in = {span_c - SPAN_BITS'(1), 1'b0};
            end else if (cfg_looping_ff) begin
               cyc_len_in = CNT_BITS'(span_c);
            end else begin
               cyc_len_in = CNT_BITS'(1);
            end
            // steps that always lead onto the cycle
            t0_in     = span_c + SPAN_BITS'(2);
            f_work_in = $signed({2'b00, frame_ff});
            state_in  = S_FINISH;
            case (kind_ff)
               KIND_TICK: begin
                  if (!cfg_bouncy_ff) dir_in = 1'b0;
                  if (!playing_ff) begin
                     acc_in = '0;
                  end else if (cfg_period_ff != '0 &&
                               acc_sat_c > ACC_BITS'(cfg_period_ff)) begin
                     acc_in        = acc_sat_c;
                     div_req.start = 1'b1;
                     state_in      = S_DIV1;
                  end else begin
                     acc_in = acc_sat_c;
                  end
               end
               KIND_BACK:    f_work_in = $signed({2'b00, frame_ff}) - work_type'(1);
               KIND_FORWARD: f_work_in = $signed({2'b00, frame_ff}) + work_type'(1);
               KIND_TOGGLE:  playing_in = ~playing_ff;
               KIND_SET: begin
                  f_work_in  = $signed({2'b00, new_frame_ff});
                  playing_in = 1'b0;
               end
               default: ;
            endcase
         end

         S_DIV1: begin
            // quotient counts whole periods strictly exceeded, remainder + 1 stays
            div_req.dividend = div_rsp.quot - ACC_BITS'(t0_ff);
            div_req.divisor  = PERIOD_BITS'(cyc_len_ff);
            if (div_rsp.done) begin
               acc_in = ACC_BITS'(div_rsp.rem) + ACC_BITS'(1);
               if (div_rsp.quot <= ACC_BITS'(t0_ff)) begin
                  step_cnt_in = CNT_BITS'(div_rsp.quot);
                  state_in    = S_STEP;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV2;
               end
            end
         end

         S_DIV2: begin
            div_req.dividend = '0;
            div_req.divisor  = PERIOD_BITS'(cyc_len_ff);
            if (div_rsp.done) begin
               step_cnt_in = CNT_BITS'(t0_ff) + div_rsp.rem[CNT_BITS-1:0];
               state_in    = S_STEP;
            end
         end

         S_STEP: begin
            if (step_cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               f_work_in   = $signed({2'b00, adv_frame});
               dir_in      = adv_dir;
               step_cnt_in = step_cnt_ff - CNT_BITS'(1);
            end
         end

         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               frame_in     = bound_c;
               rsp_frame_in = bound_c;
               rsp_dir_in   = dir_ff;
               rsp_play_in  = playing_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_ff     <= RESET_FRAME;
         dir_ff       <= 1'b0;
         playing_ff   <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         dir_ff       <= dir_in;
         playing_ff   <= playing_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      elapsed_ff   <= elapsed_in;
      new_frame_ff <= new_frame_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cyc_len_ff   <= cyc_len_in;
      t0_ff        <= t0_in;
      f_work_ff    <= f_work_in;
      step_cnt_ff  <= step_cnt_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_play_ff  <= rsp_play_in;
   end

   // a request transfer only while idle
   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_now  = rsp_frame_ff;
   assign rsp_going_back = rsp_dir_ff;
   assign rsp_is_playing = rsp_play_ff;

`ifndef SYNTH
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider finished while the sequencer was not waiting");

   a_acc_folded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 && div_rsp.done) |=>
         (acc_ff != '0 && acc_ff <= ACC_BITS'(cfg_period_ff)))
      else $error("accumulator left outside one period after the division");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && step_cnt_ff != '0) |=>
         (f_work_ff >= $signed({2'b00, lo_ff}) && f_work_ff <= $signed({2'b00, hi_ff})))
      else $error("advance step left the effective range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result appeared without a finished item");
`endif

endmodule

>>> src/fps_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on fps_pkg
module fps_divider (
   input  logic                clock,
   input  logic                reset,
   input  fps_pkg::div_req_type req,
   output fps_pkg::div_rsp_type rsp
);
   import fps_pkg::*;

   localparam int COUNT_BITS = $clog2(ACC_BITS);

   logic                   busy_ff;
   logic                   done_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [ACC_BITS-1:0]    quot_ff;
   logic [PERIOD_BITS-1:0] rem_ff;
   logic [PERIOD_BITS-1:0] divisor_ff;

   logic [PERIOD_BITS:0]   rem_shift;
   logic [PERIOD_BITS:0]   diff;
   logic                   fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[ACC_BITS-1]};
      diff      = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start && !busy_ff) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + COUNT_BITS'(1);
            if (count_ff == COUNT_BITS'(ACC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         quot_ff    <= req.dividend;
         rem_ff     <= '0;
         divisor_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[PERIOD_BITS-1:0] : rem_shift[PERIOD_BITS-1:0];
         quot_ff <= {quot_ff[ACC_BITS-2:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> src/fps_advance.sv
// one playback advance step: move by one, bounce at the range ends in bouncy mode, then wrap or clamp
// depends on fps_pkg
module fps_advance (
   input  fps_pkg::frame_type frame_cur,
   input  logic               dir_cur,
   input  fps_pkg::range_type rng,
   input  fps_pkg::mode_type  mode,
   output fps_pkg::frame_type frame_next,
   output logic               dir_next
);
   import fps_pkg::*;

   work_type cur_w;
   work_type lo_w;
   work_type hi_w;
   work_type v_w;
   logic     d;

   always_comb begin
      cur_w = $signed({2'b00, frame_cur});
      lo_w  = $signed({2'b00, rng.lo});
      hi_w  = $signed({2'b00, rng.hi});
      d     = dir_cur;
      if (mode.reverse ^ dir_cur) v_w = cur_w - work_type'(1);
      else v_w = cur_w + work_type'(1);
      if (mode.bouncy) begin
         if (v_w < lo_w) begin
            v_w = lo_w + work_type'(1);
            d   = ~d;
         end
         if (v_w > hi_w) begin
            v_w = hi_w - work_type'(1);
            d   = ~d;
         end
      end
      frame_next = in_bounds(v_w, rng, mode.looping);
      dir_next   = d;
   end

endmodule
